// ===== hw/rtl/tfrt_pkg.sv =====
// ----------------------------------------------------------------------------
// tfrt_pkg
// Shared types, constants and codes for the TCP flow RTT timestamp table.
// ----------------------------------------------------------------------------
package tfrt_pkg;

    // Table sizes
    localparam int FIRST_DEPTH    = 16;
    localparam int OVERFLOW_DEPTH = 8;
    localparam int RTT_DEPTH      = 8;

    localparam int FIRST_IDX_W = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
    localparam int OVF_IDX_W   = (OVERFLOW_DEPTH > 1) ? $clog2(OVERFLOW_DEPTH) : 1;
    localparam int RTT_IDX_W   = (RTT_DEPTH > 1) ? $clog2(RTT_DEPTH) : 1;

    // Command queue between front and back
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = CMD_PTR_W + 1;

    // Field widths
    localparam int KEY_W   = 35;
    localparam int TIME_W  = 64;
    localparam int COUNT_W = 32;

    // Header constants
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'h06;
    localparam logic [7:0]  PROTO_UDP      = 8'h11;
    localparam logic [7:0]  PROTO_ICMP     = 8'h01;
    localparam logic [15:0] ETH_LEN        = 16'd14;
    localparam logic [15:0] IP_END         = 16'd34;
    localparam logic [15:0] TCP_END        = 16'd54;
    localparam logic [15:0] UDP_END        = 16'd42;

    // Direction of a packet
    localparam logic MODE_OUTGOING = 1'b0;
    localparam logic MODE_INCOMING = 1'b1;

    // Table that took an outgoing timestamp
    localparam logic [1:0] STORED_NONE   = 2'd0;
    localparam logic [1:0] STORED_FIRST  = 2'd1;
    localparam logic [1:0] STORED_SECOND = 2'd2;
    localparam logic [1:0] STORED_THIRD  = 2'd3;

    typedef enum logic [1:0] {
        VERDICT_PASS   = 2'd0,
        VERDICT_DROP   = 2'd1,
        VERDICT_UNSPEC = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_STORE,
        OP_MEASURE,
        OP_UDP,
        OP_ICMP
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MATCH,
        BK_EXEC
    } back_state_t;

    typedef struct packed {
        logic              mode;
        logic [15:0]       frame_length;
        logic [15:0]       ether_type;
        logic [7:0]        ip_protocol;
        logic [31:0]       source_address;
        logic [31:0]       dest_address;
        logic [15:0]       source_port;
        logic [15:0]       dest_port;
        logic [15:0]       sequence_slice;
        logic [TIME_W-1:0] arrival_time;
    } item_t;

    typedef struct packed {
        verdict_t           verdict;
        logic [1:0]         stored_in;
        logic               rtt_valid;
        logic [TIME_W-1:0]  round_trip;
        logic [COUNT_W-1:0] class_count;
    } result_t;

    typedef struct packed {
        op_t               op;
        verdict_t          verdict;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] stamp;
    } cmd_t;

endpackage

// ===== hw/rtl/tfrt_front.sv =====
// ----------------------------------------------------------------------------
// tfrt_front
// Input stage: holds one header word, checks lengths and type, builds the
// flow key and hands a command to the queue.
// ----------------------------------------------------------------------------
module tfrt_front
    import tfrt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t item,
    output logic  full,
    output logic  cmd_push,
    output cmd_t  cmd,
    input  logic  cmd_full
);

    logic  held_reg;
    logic  held_next;
    item_t item_reg;
    logic  take;

    // Hold stage: stalls only when the queue is full
    assign full     = held_reg && cmd_full;
    assign take     = push && !full;
    assign cmd_push = held_reg;
    assign held_next = take || (held_reg && cmd_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
    end

    // Classification and flow key
    always_comb
    begin
        cmd.op      = OP_NONE;
        cmd.verdict = VERDICT_PASS;
        cmd.stamp   = item_reg.arrival_time;
        cmd.key     = {3'b000, item_reg.source_address}
                    + {3'b000, item_reg.dest_address}
                    + {19'd0, item_reg.source_port}
                    + {19'd0, item_reg.dest_port}
                    + {19'd0, item_reg.sequence_slice};

        if (item_reg.frame_length == 16'd0)
        begin
            cmd.verdict = VERDICT_PASS;
        end
        else if (item_reg.frame_length < ETH_LEN)
        begin
            cmd.verdict = VERDICT_DROP;
        end
        else if (item_reg.ether_type != ETHERTYPE_IPV4)
        begin
            cmd.verdict = VERDICT_UNSPEC;
        end
        else if (item_reg.frame_length < IP_END)
        begin
            cmd.verdict = VERDICT_DROP;
        end
        else if (item_reg.ip_protocol == PROTO_TCP)
        begin
            if (item_reg.frame_length < TCP_END)
            begin
                cmd.verdict = VERDICT_DROP;
            end
            else if (item_reg.mode == MODE_OUTGOING)
            begin
                cmd.op = OP_STORE;
            end
            else
            begin
                cmd.op = OP_MEASURE;
            end
        end
        else if (item_reg.ip_protocol == PROTO_UDP)
        begin
            if (item_reg.frame_length < UDP_END)
            begin
                cmd.verdict = VERDICT_DROP;
            end
            else
            begin
                cmd.op = OP_UDP;
            end
        end
        else if (item_reg.ip_protocol == PROTO_ICMP)
        begin
            cmd.op = OP_ICMP;
        end
    end

endmodule

// ===== hw/rtl/tfrt_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// tfrt_cmd_fifo
// Short command queue between the front stage and the table engine.
// ----------------------------------------------------------------------------
module tfrt_cmd_fifo
    import tfrt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t dout
);

    cmd_t                 mem_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== hw/rtl/tfrt_back.sv =====
// ----------------------------------------------------------------------------
// tfrt_back
// Table engine: matches the flow key against all tables in parallel, then
// inserts, measures or counts and loads the result register.
// ----------------------------------------------------------------------------
module tfrt_back
    import tfrt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_empty,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    // Sequencer
    back_state_t state_reg;
    back_state_t state_next;
    cmd_t        work_reg;
    logic        exec_fire;
    logic        can_load;

    // Timestamp tables
    logic [KEY_W-1:0]       first_key_reg   [FIRST_DEPTH];
    logic [TIME_W-1:0]      first_stamp_reg [FIRST_DEPTH];
    logic [FIRST_DEPTH-1:0] first_valid_reg;
    logic [KEY_W-1:0]          second_key_reg   [OVERFLOW_DEPTH];
    logic [TIME_W-1:0]         second_stamp_reg [OVERFLOW_DEPTH];
    logic [OVERFLOW_DEPTH-1:0] second_valid_reg;
    logic [KEY_W-1:0]          third_key_reg   [OVERFLOW_DEPTH];
    logic [TIME_W-1:0]         third_stamp_reg [OVERFLOW_DEPTH];
    logic [OVERFLOW_DEPTH-1:0] third_valid_reg;
    logic [KEY_W-1:0]     rtt_key_reg   [RTT_DEPTH];
    logic [TIME_W-1:0]    rtt_value_reg [RTT_DEPTH];
    logic [RTT_DEPTH-1:0] rtt_valid_reg;

    logic [COUNT_W-1:0] udp_count_reg;
    logic [COUNT_W-1:0] icmp_count_reg;

    // Match results, combinational then registered
    logic                   match1, free1, match2, free2, match3, free3, match_r, free_r;
    logic [FIRST_IDX_W-1:0] hidx1, fidx1;
    logic [OVF_IDX_W-1:0]   hidx2, fidx2, hidx3, fidx3;
    logic [RTT_IDX_W-1:0]   fidx_r;
    logic                   match1_reg, free1_reg, match2_reg, free2_reg;
    logic                   match3_reg, free3_reg, match_r_reg, free_r_reg;
    logic [FIRST_IDX_W-1:0] hidx1_reg, fidx1_reg;
    logic [OVF_IDX_W-1:0]   hidx2_reg, fidx2_reg, hidx3_reg, fidx3_reg;
    logic [RTT_IDX_W-1:0]   fidx_r_reg;

    // Execute stage
    logic              ins1, ins2, ins3, hit, ins_r;
    logic [TIME_W-1:0] sel_stamp;
    logic [TIME_W-1:0] rtt_diff;
    result_t           res;
    result_t           out_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and queue pop
    assign can_load = !out_valid_reg || pop;

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        exec_fire  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    state_next = BK_MATCH;
                end
            end
            BK_MATCH:
            begin
                state_next = BK_EXEC;
            end
            BK_EXEC:
            begin
                if (can_load)
                begin
                    exec_fire = 1'b1;
                    if (!cmd_empty)
                    begin
                        cmd_pop    = 1'b1;
                        state_next = BK_MATCH;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            work_reg <= cmd;
        end
    end

    // Parallel key compare; lowest index wins for hit and free slot
    always_comb
    begin
        match1 = 1'b0;
        free1  = 1'b0;
        hidx1  = '0;
        fidx1  = '0;
        for (int i = FIRST_DEPTH - 1; i >= 0; i--)
        begin
            if (first_valid_reg[i] && (first_key_reg[i] == work_reg.key))
            begin
                match1 = 1'b1;
                hidx1  = FIRST_IDX_W'(i);
            end
            if (!first_valid_reg[i])
            begin
                free1 = 1'b1;
                fidx1 = FIRST_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        match2 = 1'b0;
        free2  = 1'b0;
        hidx2  = '0;
        fidx2  = '0;
        match3 = 1'b0;
        free3  = 1'b0;
        hidx3  = '0;
        fidx3  = '0;
        for (int i = OVERFLOW_DEPTH - 1; i >= 0; i--)
        begin
            if (second_valid_reg[i] && (second_key_reg[i] == work_reg.key))
            begin
                match2 = 1'b1;
                hidx2  = OVF_IDX_W'(i);
            end
            if (!second_valid_reg[i])
            begin
                free2 = 1'b1;
                fidx2 = OVF_IDX_W'(i);
            end
            if (third_valid_reg[i] && (third_key_reg[i] == work_reg.key))
            begin
                match3 = 1'b1;
                hidx3  = OVF_IDX_W'(i);
            end
            if (!third_valid_reg[i])
            begin
                free3 = 1'b1;
                fidx3 = OVF_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        match_r = 1'b0;
        free_r  = 1'b0;
        fidx_r  = '0;
        for (int i = RTT_DEPTH - 1; i >= 0; i--)
        begin
            if (rtt_valid_reg[i] && (rtt_key_reg[i] == work_reg.key))
            begin
                match_r = 1'b1;
            end
            if (!rtt_valid_reg[i])
            begin
                free_r = 1'b1;
                fidx_r = RTT_IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_MATCH)
        begin
            match1_reg  <= match1;
            free1_reg   <= free1;
            hidx1_reg   <= hidx1;
            fidx1_reg   <= fidx1;
            match2_reg  <= match2;
            free2_reg   <= free2;
            hidx2_reg   <= hidx2;
            fidx2_reg   <= fidx2;
            match3_reg  <= match3;
            free3_reg   <= free3;
            hidx3_reg   <= hidx3;
            fidx3_reg   <= fidx3;
            match_r_reg <= match_r;
            free_r_reg  <= free_r;
            fidx_r_reg  <= fidx_r;
        end
    end

    // Execute: pick table, measure, count
    always_comb
    begin
        ins1 = 1'b0;
        ins2 = 1'b0;
        ins3 = 1'b0;
        if (work_reg.op == OP_STORE)
        begin
            if (!match1_reg && free1_reg)
            begin
                ins1 = 1'b1;
            end
            else if (!match2_reg && free2_reg)
            begin
                ins2 = 1'b1;
            end
            else if (!match3_reg && free3_reg)
            begin
                ins3 = 1'b1;
            end
        end

        if (match1_reg)
        begin
            sel_stamp = first_stamp_reg[hidx1_reg];
        end
        else if (match2_reg)
        begin
            sel_stamp = second_stamp_reg[hidx2_reg];
        end
        else
        begin
            sel_stamp = third_stamp_reg[hidx3_reg];
        end
        rtt_diff = work_reg.stamp - sel_stamp;

        hit   = (work_reg.op == OP_MEASURE) && (match1_reg || match2_reg || match3_reg);
        ins_r = hit && !match_r_reg && free_r_reg;

        res.verdict     = work_reg.verdict;
        res.stored_in   = STORED_NONE;
        res.rtt_valid   = hit;
        res.round_trip  = hit ? rtt_diff : '0;
        res.class_count = '0;
        if (ins1)
        begin
            res.stored_in = STORED_FIRST;
        end
        else if (ins2)
        begin
            res.stored_in = STORED_SECOND;
        end
        else if (ins3)
        begin
            res.stored_in = STORED_THIRD;
        end
        if (work_reg.op == OP_UDP)
        begin
            res.class_count = udp_count_reg + 1'b1;
        end
        else if (work_reg.op == OP_ICMP)
        begin
            res.class_count = icmp_count_reg + 1'b1;
        end
    end

    // Valid bits, counters and result flag
    assign out_valid_next = exec_fire ? 1'b1 : (pop ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_valid_reg  <= '0;
            second_valid_reg <= '0;
            third_valid_reg  <= '0;
            rtt_valid_reg    <= '0;
            udp_count_reg    <= '0;
            icmp_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (exec_fire)
            begin
                if (ins1)
                begin
                    first_valid_reg[fidx1_reg] <= 1'b1;
                end
                if (ins2)
                begin
                    second_valid_reg[fidx2_reg] <= 1'b1;
                end
                if (ins3)
                begin
                    third_valid_reg[fidx3_reg] <= 1'b1;
                end
                if (ins_r)
                begin
                    rtt_valid_reg[fidx_r_reg] <= 1'b1;
                end
                if (work_reg.op == OP_UDP)
                begin
                    udp_count_reg <= res.class_count;
                end
                if (work_reg.op == OP_ICMP)
                begin
                    icmp_count_reg <= res.class_count;
                end
            end
        end
    end

    // Table payload and result word
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            out_reg <= res;
            if (ins1)
            begin
                first_key_reg[fidx1_reg]   <= work_reg.key;
                first_stamp_reg[fidx1_reg] <= work_reg.stamp;
            end
            if (ins2)
            begin
                second_key_reg[fidx2_reg]   <= work_reg.key;
                second_stamp_reg[fidx2_reg] <= work_reg.stamp;
            end
            if (ins3)
            begin
                third_key_reg[fidx3_reg]   <= work_reg.key;
                third_stamp_reg[fidx3_reg] <= work_reg.stamp;
            end
            if (ins_r)
            begin
                rtt_key_reg[fidx_r_reg]   <= work_reg.key;
                rtt_value_reg[fidx_r_reg] <= rtt_diff;
            end
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

// ===== hw/rtl/tcp_flow_rtt_timestamp_table.sv =====
// ----------------------------------------------------------------------------
// tcp_flow_rtt_timestamp_table
// TCP round-trip time measurement from parsed headers, with flow tables.
// ----------------------------------------------------------------------------
// Path: an input word goes through the hold stage, the command queue and the
//   match and execute states before its result word is on the result ports.
// Rate: the table engine pops the next command only when it executes the last
//   one; the two-entry command queue absorbs short bursts.
// Reset: valid bits, counters and queues clear at once; no clearing pass, the
//   block takes words as soon as reset is released.
module tcp_flow_rtt_timestamp_table
    import tfrt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   item,
    output logic    full,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic cmd_push;
    logic cmd_full;
    logic cmd_empty;
    logic cmd_pop;
    cmd_t cmd_in;
    cmd_t cmd_out;

    // Front: classify and build key
    tfrt_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in),
        .cmd_full (cmd_full)
    );

    // Command queue
    tfrt_cmd_fifo u_cmd_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .dout  (cmd_out)
    );

    // Back: table engine and result register
    tfrt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule
